// ----- sv/xtea_block_encrypt_macros.svh -----
// Assertion macros shared by the XTEA checker.
`ifndef XTEA_BLOCK_ENCRYPT_MACROS_SVH
`define XTEA_BLOCK_ENCRYPT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define XTEA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/xtea_pkg.sv -----
// Shared types, constants and helper functions for the XTEA encipher block.
`default_nettype none

package xtea_pkg;

   localparam int WORD_W     = 32;
   localparam int KEY_WORDS  = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

   typedef enum logic [1:0] {
      REG_KEY_WORD0 = 2'd0,
      REG_KEY_WORD1 = 2'd1,
      REG_KEY_WORD2 = 2'd2,
      REG_KEY_WORD3 = 2'd3
   } reg_index_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   typedef struct packed {
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } blk_type;

   // ((w << 4) ^ (w >> 5)) + w, wrapping
   function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

   // round sum after n delta steps, evaluated at elaboration
   function automatic logic [WORD_W-1:0] sum_after(input int n);
      logic [2*WORD_W-1:0] prod;
      prod = (2*WORD_W)'(n) * (2*WORD_W)'(DELTA);
      return prod[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/xtea_ifs.sv -----
// Request and response stream interfaces of the XTEA encipher block.
`default_nettype none

interface xtea_req_if;
   logic                      valid;
   logic                      ready;
   logic [xtea_pkg::WORD_W-1:0] plain_left;
   logic [xtea_pkg::WORD_W-1:0] plain_right;

   modport source (output valid, output plain_left, output plain_right, input ready);
   modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

interface xtea_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [xtea_pkg::WORD_W-1:0] cipher_left;
   logic [xtea_pkg::WORD_W-1:0] cipher_right;

   modport source (output valid, output cipher_left, output cipher_right, input ready);
   modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

`default_nettype wire

// ----- sv/xtea_csr.sv -----
// APB key register file of the XTEA encipher block.
`default_nettype none

module xtea_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [xtea_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [xtea_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [xtea_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                            pready,
   output      xtea_pkg::key_type               key
);
   import xtea_pkg::*;

   key_type       key_ff;
   key_type       key_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_WORD0: key_in[0] = pwdata;
            REG_KEY_WORD1: key_in[1] = pwdata;
            REG_KEY_WORD2: key_in[2] = pwdata;
            REG_KEY_WORD3: key_in[3] = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_WORD0: prdata = key_ff[0];
         REG_KEY_WORD1: prdata = key_ff[1];
         REG_KEY_WORD2: prdata = key_ff[2];
         REG_KEY_WORD3: prdata = key_ff[3];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

`default_nettype wire

// ----- sv/xtea_half_round.sv -----
// One registered Feistel half-round of the XTEA pipeline.
`default_nettype none

module xtea_half_round #(
   parameter logic [31:0] SUM_VALUE    = 32'h0,
   parameter bit          UPDATE_RIGHT = 1'b0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire xtea_pkg::blk_type           in_blk,
   input  wire logic [xtea_pkg::WORD_W-1:0] key_word,
   output      logic                        out_valid,
   output      xtea_pkg::blk_type           out_blk
);
   import xtea_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   blk_type           blk_ff;
   blk_type           blk_in;
   logic [WORD_W-1:0] sum_key;

   // round sum is fixed per stage, only the key word varies
   assign sum_key = SUM_VALUE + key_word;

   always_comb begin
      blk_in = in_blk;
      if (UPDATE_RIGHT) begin
         blk_in.right = in_blk.right + (mix_word(in_blk.left) ^ sum_key);
      end else begin
         blk_in.left = in_blk.left + (mix_word(in_blk.right) ^ sum_key);
      end
   end

   assign valid_in = en ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

`default_nettype wire

// ----- sv/xtea_block_encrypt.sv -----
// Top level of the pipelined XTEA block encipher.
// Usage:
//  - Key: four 32-bit key words written over the APB port at byte offsets
//    0x0, 0x4, 0x8, 0xC (key word 0..3). pready is tied high; a write
//    lands at the access-phase edge. All key words are zero after reset.
//    Write the key only while no request is in flight.
//  - req_ch: one plaintext block (plain_left, plain_right) per request,
//    taken at an edge with valid and ready both high.
//  - rsp_ch: one ciphertext block per request, in request order.
//  - Pipeline: one register stage per Feistel half-round, the last being
//    the output register.
//  - Throughput: one block per clock while the receiver takes responses.
//    Each stage is one mix, one xor and one 32-bit add deep.
//  - Stall: while a response waits untaken the whole pipeline holds and
//    req_ch.ready is low; nothing is dropped or repeated. An empty output
//    register never blocks requests.
//  - Reset (synchronous, active high) empties the pipeline and clears the
//    key.
`default_nettype none

module xtea_block_encrypt #(
   parameter int CYCLES = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   xtea_req_if.sink                             req_ch,
   xtea_rsp_if.source                           rsp_ch,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [xtea_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [xtea_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [xtea_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                            pready
);
   import xtea_pkg::*;

   localparam int STAGES = 2 * CYCLES;

   key_type key;
   logic    pipe_en;
   logic    stage_valid [STAGES+1];
   blk_type stage_blk   [STAGES+1];

   xtea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // global advance: move when the output slot is free or being taken
   assign pipe_en = !stage_valid[STAGES] || rsp_ch.ready;

   assign req_ch.ready       = pipe_en;
   assign stage_valid[0]     = req_ch.valid;
   assign stage_blk[0].left  = req_ch.plain_left;
   assign stage_blk[0].right = req_ch.plain_right;

   // even stage: left word, sum before the delta step, key[sum & 3]
   // odd stage:  right word, sum after the delta step, key[(sum >> 11) & 3]
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam bit          ODD  = (k % 2) == 1;
      localparam logic [31:0] SUM  = ODD ? sum_after(k / 2 + 1) : sum_after(k / 2);
      localparam logic [1:0]  KSEL = ODD ? SUM[12:11] : SUM[1:0];

      xtea_half_round #(
         .SUM_VALUE    (SUM),
         .UPDATE_RIGHT (ODD)
      ) u_half (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (stage_valid[k]),
         .in_blk    (stage_blk[k]),
         .key_word  (key[KSEL]),
         .out_valid (stage_valid[k+1]),
         .out_blk   (stage_blk[k+1])
      );
   end

   // last half-round register doubles as the output register
   assign rsp_ch.valid        = stage_valid[STAGES];
   assign rsp_ch.cipher_left  = stage_blk[STAGES].left;
   assign rsp_ch.cipher_right = stage_blk[STAGES].right;

endmodule

`default_nettype wire

// ----- sv/xtea_checker.sv -----
// Port-level checker for the XTEA encipher block, bound to the top level.
`default_nettype none

`include "xtea_block_encrypt_macros.svh"

module xtea_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [xtea_pkg::WORD_W-1:0]     rsp_left,
   input wire logic [xtea_pkg::WORD_W-1:0]     rsp_right,
   input wire logic                            psel,
   input wire logic                            penable,
   input wire logic                            pwrite,
   input wire logic [xtea_pkg::CSR_ADDR_W-1:0] paddr,
   input wire logic [xtea_pkg::CSR_DATA_W-1:0] pwdata,
   input wire logic [xtea_pkg::CSR_DATA_W-1:0] prdata
);

   // stalled response holds
   `XTEA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left) && $stable(rsp_right), "stalled response changed")

   // an empty output slot never blocks a request
   `XTEA_ASSERT_IMPL(a_req_open, !rsp_valid, req_ready, "request blocked with empty output")

   // no response straight out of reset
   `XTEA_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid, "response valid after reset")

   // written key word reads back on the same register
   `XTEA_ASSERT_IMPL(a_key_readback, (psel && penable && pwrite) ##1 (paddr[3:2] == $past(paddr[3:2])), prdata == $past(pwdata), "key readback mismatch")

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

endmodule

bind xtea_block_encrypt xtea_checker u_xtea_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_left  (rsp_ch.cipher_left),
   .rsp_right (rsp_ch.cipher_right),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);

`default_nettype wire

// ----- bench/xtea_block_encrypt_tb.sv -----
// Self-checking bench for xtea_block_encrypt: plaintext blocks under changing keys.
`timescale 1ns / 100ps

class cipher_checker;
   xtea_pkg::key_type key;
   xtea_pkg::blk_type due_blocks[$];
   int rounds;
   int unsigned requests, responses, errors;

   function new(int cycle_count);
      rounds = cycle_count;
      key = '0;
      requests = 0;
      responses = 0;
      errors = 0;
   endfunction

   function void set_key_word(xtea_pkg::reg_index_type idx,
                              logic [xtea_pkg::WORD_W-1:0] value);
      key[idx] = value;
   endfunction

   // Feistel network: each loop pass applies the left and then the right half-round
   function xtea_pkg::blk_type encipher(xtea_pkg::blk_type plain);
      logic [xtea_pkg::WORD_W-1:0] v0, v1, sum, mixed;
      xtea_pkg::blk_type cipher;
      v0 = plain.left;
      v1 = plain.right;
      sum = '0;
      for (int n = 0; n < rounds; n++) begin
         mixed = ((v1 << 4) ^ (v1 >> 5)) + v1;
         v0 = v0 + (mixed ^ (sum + key[sum[1:0]]));
         sum = sum + xtea_pkg::DELTA;
         mixed = ((v0 << 4) ^ (v0 >> 5)) + v0;
         v1 = v1 + (mixed ^ (sum + key[sum[12:11]]));
      end
      cipher.left = v0;
      cipher.right = v1;
      return cipher;
   endfunction

   function void note_request(xtea_pkg::blk_type plain);
      requests++;
      due_blocks.push_back(encipher(plain));
   endfunction

   function void check_block(xtea_pkg::blk_type got);
      xtea_pkg::blk_type want;
      responses++;
      if (due_blocks.size() == 0) begin
         errors++;
         $display("%0t: response %08h %08h with no request outstanding",
                  $time, got.left, got.right);
         return;
      end
      want = due_blocks.pop_front();
      if (got.left !== want.left) begin
         errors++;
         $display("%0t: cipher_left mismatch, expected %08h, actual %08h",
                  $time, want.left, got.left);
      end
      if (got.right !== want.right) begin
         errors++;
         $display("%0t: cipher_right mismatch, expected %08h, actual %08h",
                  $time, want.right, got.right);
      end
   endfunction
endclass

module xtea_block_encrypt_tb;
   import xtea_pkg::*;

   localparam int CIPHER_CYCLES    = 32;
   localparam int LATENCY          = 2 * CIPHER_CYCLES;  // one stage per half-round
   localparam int PHASES           = 8;
   localparam int BLOCKS_PER_PHASE = 225;
   localparam int STALL_LIMIT      = 2000;               // quiet cycles before giving up

   typedef logic [WORD_W-1:0] word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // APB key port
   logic                  psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   xtea_req_if req_ch();
   xtea_rsp_if rsp_ch();

   // idling mix of the current phase, in percent per cycle
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   int unsigned key_settings = 0;
   int unsigned quiet_cycles = 0;

   cipher_checker ciphers = new(CIPHER_CYCLES);

   xtea_block_encrypt #(.CYCLES(CIPHER_CYCLES)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random back-pressure at the phase's stall rate.
   always @(posedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);

   // Monitor: every edge sees pre-edge values, so both handshakes are sampled
   // exactly as the block sees them. The watchdog sits last in this process.
   always @(posedge clock) begin
      blk_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.left = req_ch.plain_left;
            seen.right = req_ch.plain_right;
            ciphers.note_request(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.left = rsp_ch.cipher_left;
            seen.right = rsp_ch.cipher_right;
            ciphers.check_block(seen);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: nothing accepted for %0d cycles, %0d requests outstanding",
                     $time, STALL_LIMIT, ciphers.due_blocks.size());
            $display("xtea_block_encrypt regression: fail");
            $finish;
         end
      end
   end

   // Mostly random words, with a fair share of all-zero, all-one,
   // one-hot and one-cold values.
   function automatic word_type pick_word();
      int unsigned bit_pos;
      bit_pos = $urandom_range(WORD_W-1);
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1) << bit_pos;
         3:       return ~(word_type'(1) << bit_pos);
         default: return word_type'($urandom);
      endcase
   endfunction

   // One request; the sender idles first at the phase's rate. valid is
   // left high on return so back-to-back requests need no gap.
   task automatic send_block(input word_type left_word, input word_type right_word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.plain_left <= left_word;
      req_ch.plain_right <= right_word;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending and wait until every outstanding request has its response.
   // Always advances at least one edge, so the monitor has caught up.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (ciphers.due_blocks.size() != 0);
   endtask

   // APB writes of the key words selected by mask, back to back.
   // The checker's key follows each write once it has landed.
   task automatic load_key(input key_type new_key, input logic [KEY_WORDS-1:0] mask);
      for (int i = 0; i < KEY_WORDS; i++) begin
         if (mask[i]) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {reg_index_type'(i), 2'b00};
            pwdata <= new_key[i];
            @(posedge clock);
            penable <= 1'b1;
            do @(posedge clock); while (!pready);
            ciphers.set_key_word(reg_index_type'(i), new_key[i]);
         end
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      key_settings++;
   endtask

   // Corner plaintexts: all zero, all one, mixed halves, single high and
   // low bits, alternating bits, and a plain ASCII block.
   task automatic send_corner_blocks();
      word_type lefts[8]  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                              32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 32'h4142_4344};
      word_type rights[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                              32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 32'h4546_4748};
      for (int i = 0; i < 8; i++)
         send_block(lefts[i], rights[i]);
   endtask

   initial begin
      key_type next_key;
      logic [KEY_WORDS-1:0] mask;
      int pause_at;

      req_ch.valid = 1'b0;
      req_ch.plain_left = '0;
      req_ch.plain_right = '0;
      rsp_ch.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling. First under the key as reset left it
      // (never written, so all zero).
      send_corner_blocks();

      // Byte-sequence key, every word distinct.
      wait_drained();
      load_key({32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203}, '1);
      send_corner_blocks();

      // All-ones key.
      wait_drained();
      load_key('1, '1);
      send_corner_blocks();

      // Random part. Each phase starts idle with a new key, then runs one
      // of four idling mixes: none, sender 80%, receiver 80%, both 25%.
      // Later phases rewrite only some key words, so stale words must hold.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0:       next_key = '0;
            1:       next_key = '1;
            default: for (int w = 0; w < KEY_WORDS; w++) next_key[w] = pick_word();
         endcase
         mask = (phase >= 4) ? KEY_WORDS'($urandom_range(1, 15)) : '1;
         load_key(next_key, mask);

         case (phase % 4)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase

         // somewhere inside the phase the sender holds off until the pipe is empty
         pause_at = $urandom_range(BLOCKS_PER_PHASE-1);
         for (int i = 0; i < BLOCKS_PER_PHASE; i++) begin
            if (i == pause_at)
               wait_drained();
            send_block(pick_word(), pick_word());
         end
      end

      // Drain, then watch a full pipeline depth for stray responses.
      wait_drained();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (LATENCY + 8) @(posedge clock);

      $display("Enciphered %0d requests under %0d key loads, idle and stalled mixes.",
               ciphers.requests, key_settings);
      $display("Checked %0d responses, %0d field errors, %0d requests unanswered.",
               ciphers.responses, ciphers.errors, ciphers.due_blocks.size());
      if (ciphers.errors == 0 && ciphers.due_blocks.size() == 0)
         $display("xtea_block_encrypt regression: pass");
      else
         $display("xtea_block_encrypt regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/xtea_pkg.sv
sv/xtea_ifs.sv
sv/xtea_csr.sv
sv/xtea_half_round.sv
sv/xtea_block_encrypt.sv
sv/xtea_checker.sv
bench/xtea_block_encrypt_tb.sv
